// File: hdl/xcr_pkg.sv
// Shared types and constants for the XMODEM-CRC receiver.
// Payload structs, phase and job encodings, byte-wise CRC-16 function.
// No dependencies.
package xcr_pkg;

  localparam int unsigned SHORT_PAYLOAD = 128;

  // line control bytes
  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_C   = 8'h43;
  localparam logic [7:0] B_NONE = 8'h00;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // event kinds
  localparam logic [1:0] EV_START   = 2'd0;
  localparam logic [1:0] EV_BYTE    = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;

  // result kinds
  localparam logic [1:0] RK_TX      = 2'd0;
  localparam logic [1:0] RK_PAYLOAD = 2'd1;
  localparam logic [1:0] RK_VERDICT = 2'd2;
  localparam logic [1:0] RK_FINISH  = 2'd3;

  // verdicts
  localparam logic [1:0] VD_ACCEPT = 2'd0;
  localparam logic [1:0] VD_DUP    = 2'd1;
  localparam logic [1:0] VD_REJECT = 2'd2;

  // finish status
  localparam logic [1:0] FS_COMPLETE = 2'd0;
  localparam logic [1:0] FS_CANCEL   = 2'd1;
  localparam logic [1:0] FS_SYNC     = 2'd2;
  localparam logic [1:0] FS_RETRIES  = 2'd3;

  // action queued for the end of a flush
  localparam logic [1:0] AF_RESUME   = 2'd0;
  localparam logic [1:0] AF_COMPLETE = 2'd1;
  localparam logic [1:0] AF_CANCEL   = 2'd2;
  localparam logic [1:0] AF_ABORT    = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_CAN2,
    PH_PACKET,
    PH_FLUSH
  } phase_t;

  typedef enum logic [2:0] {
    J_TX,
    J_PAYLOAD,
    J_VERDICT,
    J_VERDICT_ACK,
    J_ACK_FIN,
    J_CAN_FIN
  } job_kind_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] line_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic [9:0]  payload_offset;
    logic [1:0]  verdict;
    logic [1:0]  finish_status;
    logic [31:0] total_bytes;
    logic        last_result;
  } out_item_t;

  // one input's worth of results, expanded by the back end
  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  byte_val;
    logic [9:0]  offset;
    logic [1:0]  verdict;
    logic [1:0]  status;
    logic [31:0] total;
  } job_t;

  // index of the last result of a job
  function automatic logic [1:0] job_last_idx(job_kind_t k);
    logic [1:0] n;
    unique case (k)
      J_VERDICT_ACK, J_ACK_FIN: n = 2'd1;
      J_CAN_FIN:                n = 2'd3;
      default:                  n = 2'd0;
    endcase
    return n;
  endfunction

  // CRC-16/XMODEM over one byte, MSB first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: hdl/xmodem_crc_receiver.sv
// XMODEM-CRC receiver top level: front end, job queue, result back end.
// Depends on xcr_pkg, xcr_front, xcr_queue, xcr_back.
//
//   channel  direction  handshake            beat
//   in_      input      in_valid/in_ready    one event (start, line byte, timeout)
//   out_     output     out_valid/out_ready  one result (tx byte, payload, verdict, finish)
//   cfg_     input      cfg_wr_en            retry_limit, written at once
//
// An event is taken every cycle while the job queue has room; its state
// update and CRC byte step complete in that cycle. Results leave at one per
// cycle while out_ready is high, passing through the job queue and the back end's output
// register, so events that cause two or four results (verdict with ACK, session end)
// hold in_ready low once the queue of QUEUE_DEPTH jobs fills. Reset is synchronous,
// active low, and returns the block to idle with retry_limit at 16.
module xmodem_crc_receiver #(
  parameter int LONG_PAYLOAD = 1024,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  xcr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output xcr_pkg::out_item_t out_data
);

  xcr_pkg::job_t push_job, head_job;
  logic          push, q_full, head_valid, pop;

  xcr_front #(
    .LONG_PAYLOAD(LONG_PAYLOAD)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .q_full     (q_full),
    .job_push   (push),
    .job        (push_job)
  );

  xcr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_job),
    .full     (q_full),
    .pop_valid(head_valid),
    .pop      (pop),
    .pop_data (head_job)
  );

  xcr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .job_valid(head_valid),
    .job      (head_job),
    .job_pop  (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// File: hdl/xcr_queue.sv
// Small job queue between the protocol front end and the result back end.
// Depends on xcr_pkg (job_t).
module xcr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  xcr_pkg::job_t push_data,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output xcr_pkg::job_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  xcr_pkg::job_t slots_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  logic do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// File: hdl/xcr_front.sv
// Protocol front end: takes events, runs the XMODEM-CRC receive state and
// the running CRC, and queues one job per event that yields results.
// Depends on xcr_pkg.
module xcr_front #(
  parameter int LONG_PAYLOAD = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [6:0]       cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  xcr_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             job_push,
  output xcr_pkg::job_t    job
);

  localparam logic [10:0] LONG_SZ  = 11'(LONG_PAYLOAD);
  localparam logic [10:0] SHORT_SZ = 11'(xcr_pkg::SHORT_PAYLOAD);

  xcr_pkg::phase_t phase_r, phase_nxt;
  logic [6:0]  retry_limit_r;
  logic [7:0]  expected_seq_r, expected_seq_nxt;
  logic        long_r, long_nxt;
  logic [7:0]  pending_r, pending_nxt;
  logic [6:0]  retries_r, retries_nxt;
  logic [10:0] pos_r, pos_nxt;
  logic [7:0]  got_seq_r, got_seq_nxt;
  logic [7:0]  got_inv_r, got_inv_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  got_crc_hi_r, got_crc_hi_nxt;
  logic [31:0] total_r, total_nxt;
  logic [1:0]  after_r, after_nxt;

  logic accept;
  logic job_vld;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign job_push = accept && job_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= 7'd16;
    end else if (cfg_wr_en) begin
      retry_limit_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= xcr_pkg::PH_IDLE;
      expected_seq_r <= 8'd1;
      long_r         <= 1'b0;
      pending_r      <= xcr_pkg::B_C;
      retries_r      <= 7'd16;
      pos_r          <= '0;
      got_seq_r      <= '0;
      got_inv_r      <= '0;
      crc_r          <= '0;
      got_crc_hi_r   <= '0;
      total_r        <= '0;
      after_r        <= xcr_pkg::AF_RESUME;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      expected_seq_r <= expected_seq_nxt;
      long_r         <= long_nxt;
      pending_r      <= pending_nxt;
      retries_r      <= retries_nxt;
      pos_r          <= pos_nxt;
      got_seq_r      <= got_seq_nxt;
      got_inv_r      <= got_inv_nxt;
      crc_r          <= crc_nxt;
      got_crc_hi_r   <= got_crc_hi_nxt;
      total_r        <= total_nxt;
      after_r        <= after_nxt;
    end
  end

  always_comb begin
    logic [10:0] size;
    logic [6:0]  ret_dec;
    logic [7:0]  b;
    logic        good;
    logic [7:0]  pend_t;

    phase_nxt        = phase_r;
    expected_seq_nxt = expected_seq_r;
    long_nxt         = long_r;
    pending_nxt      = pending_r;
    retries_nxt      = retries_r;
    pos_nxt          = pos_r;
    got_seq_nxt      = got_seq_r;
    got_inv_nxt      = got_inv_r;
    crc_nxt          = crc_r;
    got_crc_hi_nxt   = got_crc_hi_r;
    total_nxt        = total_r;
    after_nxt        = after_r;
    job_vld          = 1'b0;
    job              = '0;

    b       = in_data.line_byte;
    size    = long_r ? LONG_SZ : SHORT_SZ;
    ret_dec = (retries_r == '0) ? '0 : retries_r - 7'd1;
    good    = (got_seq_r == ~got_inv_r) && (crc_r == {got_crc_hi_r, b});
    pend_t  = (pending_r == xcr_pkg::B_C) ? xcr_pkg::B_C : xcr_pkg::B_NONE;

    unique case (in_data.event_kind)
      xcr_pkg::EV_START: begin
        expected_seq_nxt = 8'd1;
        long_nxt         = 1'b0;
        pending_nxt      = xcr_pkg::B_C;
        retries_nxt      = retry_limit_r;
        pos_nxt          = '0;
        got_seq_nxt      = '0;
        got_inv_nxt      = '0;
        crc_nxt          = '0;
        got_crc_hi_nxt   = '0;
        total_nxt        = '0;
        if (retry_limit_r == '0) begin
          phase_nxt = xcr_pkg::PH_FLUSH;
          after_nxt = xcr_pkg::AF_ABORT;
        end else begin
          phase_nxt    = xcr_pkg::PH_HEADER;
          after_nxt    = xcr_pkg::AF_RESUME;
          job_vld      = 1'b1;
          job.kind     = xcr_pkg::J_TX;
          job.byte_val = xcr_pkg::B_C;
        end
      end

      xcr_pkg::EV_BYTE: begin
        unique case (phase_r)
          xcr_pkg::PH_HEADER, xcr_pkg::PH_CAN2: begin
            // any unrecognised byte opens a packet of the last size
            phase_nxt = xcr_pkg::PH_PACKET;
            pos_nxt   = '0;
            crc_nxt   = '0;
            if (phase_r == xcr_pkg::PH_CAN2) begin
              if (b == xcr_pkg::B_CAN) begin
                phase_nxt = xcr_pkg::PH_FLUSH;
                after_nxt = xcr_pkg::AF_CANCEL;
              end
            end else begin
              priority if (b == xcr_pkg::B_SOH) begin
                long_nxt = 1'b0;
              end else if (b == xcr_pkg::B_STX) begin
                long_nxt = 1'b1;
              end else if (b == xcr_pkg::B_EOT) begin
                phase_nxt = xcr_pkg::PH_FLUSH;
                after_nxt = xcr_pkg::AF_COMPLETE;
              end else if (b == xcr_pkg::B_CAN) begin
                phase_nxt = xcr_pkg::PH_CAN2;
              end else begin
                long_nxt = long_r;
              end
            end
          end

          xcr_pkg::PH_PACKET: begin
            pos_nxt = pos_r + 11'd1;
            priority if (pos_r == 11'd0) begin
              got_seq_nxt = b;
            end else if (pos_r == 11'd1) begin
              got_inv_nxt = b;
            end else if (pos_r < size + 11'd2) begin
              crc_nxt      = xcr_pkg::crc_byte(crc_r, b);
              job_vld      = 1'b1;
              job.kind     = xcr_pkg::J_PAYLOAD;
              job.byte_val = b;
              job.offset   = 10'(pos_r - 11'd2);
            end else if (pos_r == size + 11'd2) begin
              got_crc_hi_nxt = b;
            end else begin
              // low CRC byte: verdict
              pos_nxt = pos_r;
              job_vld = 1'b1;
              if (good && got_seq_r == expected_seq_r) begin
                total_nxt        = total_r + 32'(size);
                expected_seq_nxt = expected_seq_r + 8'd1;
                retries_nxt      = retry_limit_r;
                pending_nxt      = xcr_pkg::B_ACK;
                phase_nxt        = xcr_pkg::PH_HEADER;
                job.kind         = xcr_pkg::J_VERDICT_ACK;
                job.verdict      = xcr_pkg::VD_ACCEPT;
              end else if (good && got_seq_r == expected_seq_r - 8'd1) begin
                pending_nxt = xcr_pkg::B_ACK;
                phase_nxt   = xcr_pkg::PH_HEADER;
                job.kind    = xcr_pkg::J_VERDICT_ACK;
                job.verdict = xcr_pkg::VD_DUP;
              end else if (good) begin
                phase_nxt   = xcr_pkg::PH_FLUSH;
                after_nxt   = xcr_pkg::AF_ABORT;
                job.kind    = xcr_pkg::J_VERDICT;
                job.verdict = xcr_pkg::VD_REJECT;
              end else begin
                retries_nxt = ret_dec;
                pending_nxt = xcr_pkg::B_NAK;
                phase_nxt   = xcr_pkg::PH_FLUSH;
                after_nxt   = (ret_dec == '0) ? xcr_pkg::AF_ABORT : xcr_pkg::AF_RESUME;
                job.kind    = xcr_pkg::J_VERDICT;
                job.verdict = xcr_pkg::VD_REJECT;
              end
            end
          end

          default: ;
        endcase
      end

      xcr_pkg::EV_TIMEOUT: begin
        unique case (phase_r)
          xcr_pkg::PH_HEADER, xcr_pkg::PH_CAN2: begin
            retries_nxt = ret_dec;
            pending_nxt = pend_t;
            if (ret_dec == '0) begin
              phase_nxt = xcr_pkg::PH_FLUSH;
              after_nxt = xcr_pkg::AF_ABORT;
            end else begin
              phase_nxt = xcr_pkg::PH_HEADER;
              if (pend_t != xcr_pkg::B_NONE) begin
                job_vld      = 1'b1;
                job.kind     = xcr_pkg::J_TX;
                job.byte_val = pend_t;
              end
            end
          end

          xcr_pkg::PH_PACKET: begin
            retries_nxt = ret_dec;
            pending_nxt = xcr_pkg::B_NAK;
            phase_nxt   = xcr_pkg::PH_FLUSH;
            after_nxt   = (ret_dec == '0) ? xcr_pkg::AF_ABORT : xcr_pkg::AF_RESUME;
          end

          xcr_pkg::PH_FLUSH: begin
            unique case (after_r)
              xcr_pkg::AF_RESUME: begin
                phase_nxt = xcr_pkg::PH_HEADER;
                if (pending_r != xcr_pkg::B_NONE) begin
                  job_vld      = 1'b1;
                  job.kind     = xcr_pkg::J_TX;
                  job.byte_val = pending_r;
                end
              end
              xcr_pkg::AF_COMPLETE, xcr_pkg::AF_CANCEL: begin
                phase_nxt  = xcr_pkg::PH_IDLE;
                job_vld    = 1'b1;
                job.kind   = xcr_pkg::J_ACK_FIN;
                job.status = (after_r == xcr_pkg::AF_COMPLETE) ?
                             xcr_pkg::FS_COMPLETE : xcr_pkg::FS_CANCEL;
              end
              default: begin
                phase_nxt  = xcr_pkg::PH_IDLE;
                job_vld    = 1'b1;
                job.kind   = xcr_pkg::J_CAN_FIN;
                job.status = (retries_r == '0) ? xcr_pkg::FS_RETRIES : xcr_pkg::FS_SYNC;
              end
            endcase
          end

          default: ;
        endcase
      end

      default: ;
    endcase

    job.total = total_nxt;
  end

endmodule

// File: hdl/xcr_back.sv
// Result back end: pops jobs and expands each into one to four result beats
// held in an output register. Depends on xcr_pkg.
module xcr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  xcr_pkg::job_t     job,
  output logic              job_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output xcr_pkg::out_item_t out_data
);

  xcr_pkg::job_t cur_r;
  logic [1:0]    sub_r;
  logic          busy_r;
  logic          last;
  logic          take;

  assign last      = (sub_r == xcr_pkg::job_last_idx(cur_r.kind));
  assign take      = out_valid && out_ready;
  assign out_valid = busy_r;
  // next job loads as the final beat of the current one leaves
  assign job_pop   = job_valid && (!busy_r || (take && last));

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sub_r  <= '0;
    end else if (job_pop) begin
      busy_r <= 1'b1;
      sub_r  <= '0;
    end else if (take) begin
      if (last) begin
        busy_r <= 1'b0;
        sub_r  <= '0;
      end else begin
        sub_r <= sub_r + 2'd1;
      end
    end
  end

  always_comb begin
    out_data             = '0;
    out_data.total_bytes = cur_r.total;
    out_data.last_result = last;
    unique case (cur_r.kind)
      xcr_pkg::J_TX: begin
        out_data.result_kind = xcr_pkg::RK_TX;
        out_data.out_byte    = cur_r.byte_val;
      end
      xcr_pkg::J_PAYLOAD: begin
        out_data.result_kind    = xcr_pkg::RK_PAYLOAD;
        out_data.out_byte       = cur_r.byte_val;
        out_data.payload_offset = cur_r.offset;
      end
      xcr_pkg::J_VERDICT: begin
        out_data.result_kind = xcr_pkg::RK_VERDICT;
        out_data.verdict     = cur_r.verdict;
      end
      xcr_pkg::J_VERDICT_ACK: begin
        if (sub_r == 2'd0) begin
          out_data.result_kind = xcr_pkg::RK_VERDICT;
          out_data.verdict     = cur_r.verdict;
        end else begin
          out_data.result_kind = xcr_pkg::RK_TX;
          out_data.out_byte    = xcr_pkg::B_ACK;
        end
      end
      xcr_pkg::J_ACK_FIN: begin
        if (sub_r == 2'd0) begin
          out_data.result_kind = xcr_pkg::RK_TX;
          out_data.out_byte    = xcr_pkg::B_ACK;
        end else begin
          out_data.result_kind   = xcr_pkg::RK_FINISH;
          out_data.finish_status = cur_r.status;
        end
      end
      xcr_pkg::J_CAN_FIN: begin
        if (sub_r != 2'd3) begin
          out_data.result_kind = xcr_pkg::RK_TX;
          out_data.out_byte    = xcr_pkg::B_CAN;
        end else begin
          out_data.result_kind   = xcr_pkg::RK_FINISH;
          out_data.finish_status = cur_r.status;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/xcr_checker.sv
// Port-level checks for the XMODEM-CRC receiver, bound to the top level.
// Depends on xcr_pkg and xmodem_crc_receiver.
module xcr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input xcr_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input xcr_pkg::out_item_t out_data
);

  // a stalled event beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("event beat changed while stalled");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // finish always closes the results of its event
  a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == xcr_pkg::RK_FINISH |-> out_data.last_result)
    else $error("finish result not marked last");

  // payload bytes come one per event, with no verdict or status bits
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == xcr_pkg::RK_PAYLOAD |->
      out_data.last_result && out_data.verdict == 2'd0 && out_data.finish_status == 2'd0)
    else $error("malformed payload result");

  // results of one event follow back to back with the same byte total
  a_group_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_result |=>
      out_valid && out_data.total_bytes == $past(out_data.total_bytes))
    else $error("broken result group");

endmodule

bind xmodem_crc_receiver xcr_checker u_xcr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// File: dv/tb_top.sv
// Self-checking testbench for xmodem_crc_receiver: random-gap driver and monitor,
// with a cycle-free receiver predictor that checks every result beat in order.
// Depends on xcr_pkg and the receiver RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SETTLE_CYCLES = 12;
  localparam int          MAX_REPORTS   = 40;
  localparam logic [1:0]  EV_SPARE      = 2'd3;   // unused event code, must be ignored

  typedef enum int {FLAW_NONE, FLAW_CUT} flaw_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [6:0]         cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  xcr_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  xcr_pkg::out_item_t out_data;

  xmodem_crc_receiver dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------- receiver predictor
  xcr_pkg::phase_t rx_phase   = xcr_pkg::PH_IDLE;
  logic [6:0]      rx_limit   = 7'd16;
  logic [7:0]      rx_exp_seq = 8'd1;
  logic            rx_long    = 1'b0;
  logic [7:0]      rx_pending = xcr_pkg::B_C;
  logic [6:0]      rx_retries = 7'd16;
  logic [10:0]     rx_pos     = '0;
  logic [7:0]      rx_seq     = '0;
  logic [7:0]      rx_seq_inv = '0;
  logic [15:0]     rx_crc     = '0;
  logic [15:0]     rx_crc_got = '0;
  logic [31:0]     rx_total   = '0;
  logic [1:0]      rx_after   = xcr_pkg::AF_RESUME;

  xcr_pkg::out_item_t step_out[$];      // results of the event being predicted
  xcr_pkg::out_item_t results_due[$];   // predicted results not yet seen on out_

  // CRC-16, poly 0x1021, shifted one data bit at a time
  function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ d[i];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ 16'h1021;
    end
    return acc;
  endfunction

  function automatic void post(logic [1:0] k, logic [7:0] b, logic [9:0] off,
                               logic [1:0] vd, logic [1:0] fs);
    xcr_pkg::out_item_t r;
    r = '0;
    r.result_kind    = k;
    r.out_byte       = b;
    r.payload_offset = off;
    r.verdict        = vd;
    r.finish_status  = fs;
    r.total_bytes    = rx_total;
    step_out.push_back(r);
  endfunction

  function automatic void use_retry();
    if (rx_retries != 0) rx_retries = rx_retries - 7'd1;
  endfunction

  function automatic void enter_flush(logic [1:0] action);
    rx_phase = xcr_pkg::PH_FLUSH;
    rx_after = action;
  endfunction

  function automatic void open_packet();
    rx_phase   = xcr_pkg::PH_PACKET;
    rx_pos     = '0;
    rx_crc     = '0;
    rx_crc_got = '0;
  endfunction

  function automatic void judge_packet();
    logic intact;
    intact = (rx_seq == ~rx_seq_inv) && (rx_crc == rx_crc_got);
    if (intact && rx_seq == rx_exp_seq) begin
      rx_total   = rx_total + (rx_long ? 32'd1024 : 32'd128);
      rx_exp_seq = rx_exp_seq + 8'd1;
      rx_retries = rx_limit;
      rx_pending = xcr_pkg::B_ACK;
      post(xcr_pkg::RK_VERDICT, '0, '0, xcr_pkg::VD_ACCEPT, '0);
      post(xcr_pkg::RK_TX, xcr_pkg::B_ACK, '0, '0, '0);
      rx_phase = xcr_pkg::PH_HEADER;
    end else if (intact && rx_seq == rx_exp_seq - 8'd1) begin
      rx_pending = xcr_pkg::B_ACK;
      post(xcr_pkg::RK_VERDICT, '0, '0, xcr_pkg::VD_DUP, '0);
      post(xcr_pkg::RK_TX, xcr_pkg::B_ACK, '0, '0, '0);
      rx_phase = xcr_pkg::PH_HEADER;
    end else if (intact) begin
      post(xcr_pkg::RK_VERDICT, '0, '0, xcr_pkg::VD_REJECT, '0);
      enter_flush(xcr_pkg::AF_ABORT);
    end else begin
      post(xcr_pkg::RK_VERDICT, '0, '0, xcr_pkg::VD_REJECT, '0);
      use_retry();
      rx_pending = xcr_pkg::B_NAK;
      enter_flush(rx_retries == 0 ? xcr_pkg::AF_ABORT : xcr_pkg::AF_RESUME);
    end
  endfunction

  function automatic void packet_byte(logic [7:0] b);
    int len;
    int p;
    len = rx_long ? 1024 : 128;
    p   = rx_pos;
    if (p == 0) rx_seq = b;
    else if (p == 1) rx_seq_inv = b;
    else if (p < len + 2) begin
      rx_crc = crc16_step(rx_crc, b);
      post(xcr_pkg::RK_PAYLOAD, b, 10'(p - 2), '0, '0);
    end else if (p == len + 2) rx_crc_got = {b, 8'h00};
    else begin
      rx_crc_got[7:0] = b;
      judge_packet();
    end
    if (p <= len + 2) rx_pos = rx_pos + 11'd1;
  endfunction

  function automatic void header_timeout();
    use_retry();
    if (rx_pending != xcr_pkg::B_C) rx_pending = xcr_pkg::B_NONE;
    rx_phase = xcr_pkg::PH_HEADER;
    if (rx_retries == 0) enter_flush(xcr_pkg::AF_ABORT);
    else if (rx_pending != xcr_pkg::B_NONE) post(xcr_pkg::RK_TX, rx_pending, '0, '0, '0);
  endfunction

  function automatic void close_flush();
    if (rx_after == xcr_pkg::AF_RESUME) begin
      rx_phase = xcr_pkg::PH_HEADER;
      if (rx_pending != xcr_pkg::B_NONE) post(xcr_pkg::RK_TX, rx_pending, '0, '0, '0);
    end else begin
      rx_phase = xcr_pkg::PH_IDLE;
      if (rx_after == xcr_pkg::AF_COMPLETE || rx_after == xcr_pkg::AF_CANCEL) begin
        post(xcr_pkg::RK_TX, xcr_pkg::B_ACK, '0, '0, '0);
        post(xcr_pkg::RK_FINISH, '0, '0, '0,
             rx_after == xcr_pkg::AF_COMPLETE ? xcr_pkg::FS_COMPLETE : xcr_pkg::FS_CANCEL);
      end else begin
        repeat (3) post(xcr_pkg::RK_TX, xcr_pkg::B_CAN, '0, '0, '0);
        post(xcr_pkg::RK_FINISH, '0, '0, '0,
             rx_retries == 0 ? xcr_pkg::FS_RETRIES : xcr_pkg::FS_SYNC);
      end
    end
  endfunction

  function automatic void receiver_step(xcr_pkg::in_item_t ev);
    step_out.delete();
    case (ev.event_kind)
      xcr_pkg::EV_START: begin
        rx_exp_seq = 8'd1;
        rx_long    = 1'b0;
        rx_pending = xcr_pkg::B_C;
        rx_retries = rx_limit;
        rx_pos     = '0;
        rx_seq     = '0;
        rx_seq_inv = '0;
        rx_crc     = '0;
        rx_crc_got = '0;
        rx_total   = '0;
        rx_after   = xcr_pkg::AF_RESUME;
        rx_phase   = xcr_pkg::PH_HEADER;
        if (rx_retries == 0) enter_flush(xcr_pkg::AF_ABORT);
        else post(xcr_pkg::RK_TX, xcr_pkg::B_C, '0, '0, '0);
      end
      xcr_pkg::EV_BYTE: begin
        if (rx_phase == xcr_pkg::PH_HEADER) begin
          case (ev.line_byte)
            xcr_pkg::B_SOH: begin
              rx_long = 1'b0;
              open_packet();
            end
            xcr_pkg::B_STX: begin
              rx_long = 1'b1;
              open_packet();
            end
            xcr_pkg::B_EOT: enter_flush(xcr_pkg::AF_COMPLETE);
            xcr_pkg::B_CAN: rx_phase = xcr_pkg::PH_CAN2;
            default: open_packet();
          endcase
        end else if (rx_phase == xcr_pkg::PH_CAN2) begin
          if (ev.line_byte == xcr_pkg::B_CAN) enter_flush(xcr_pkg::AF_CANCEL);
          else open_packet();
        end else if (rx_phase == xcr_pkg::PH_PACKET) begin
          packet_byte(ev.line_byte);
        end
      end
      xcr_pkg::EV_TIMEOUT: begin
        if (rx_phase == xcr_pkg::PH_HEADER || rx_phase == xcr_pkg::PH_CAN2) header_timeout();
        else if (rx_phase == xcr_pkg::PH_PACKET) begin
          use_retry();
          rx_pending = xcr_pkg::B_NAK;
          enter_flush(rx_retries == 0 ? xcr_pkg::AF_ABORT : xcr_pkg::AF_RESUME);
        end else if (rx_phase == xcr_pkg::PH_FLUSH) close_flush();
      end
      default: ;
    endcase
    foreach (step_out[i]) begin
      xcr_pkg::out_item_t r;
      r = step_out[i];
      r.last_result = (i == step_out.size() - 1);
      results_due.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- idling
  // alternates stretches of back-to-back beats with stretches of random gaps
  function automatic int pick_wait(inout int stretch, inout bit steady);
    if (stretch == 0) begin
      stretch = $urandom_range(20, 80);
      steady  = ($urandom_range(0, 2) == 0);
    end
    stretch--;
    return steady ? 0 : $urandom_range(0, 11);
  endfunction

  // ---------------------------------------------------------------- driver
  xcr_pkg::in_item_t line_events[$];
  int                in_wait = 0;
  int                in_stretch = 0;
  bit                in_steady = 1'b0;
  int                events_sent = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        receiver_step(in_data);
        events_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (line_events.size() > 0) begin
          in_data  <= line_events.pop_front();
          in_valid <= 1'b1;
          in_wait = pick_wait(in_stretch, in_steady);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int out_hold = 0;
  int out_stretch = 0;
  bit out_steady = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int payload_seen = 0;
  int verdicts_seen = 0;
  int accepts_seen = 0;
  int finishes_seen = 0;

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  function automatic void compare_result(xcr_pkg::out_item_t want, xcr_pkg::out_item_t got);
    check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
    check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
    check_field("payload_offset", 32'(want.payload_offset), 32'(got.payload_offset));
    check_field("verdict", 32'(want.verdict), 32'(got.verdict));
    check_field("finish_status", 32'(want.finish_status), 32'(got.finish_status));
    check_field("total_bytes", want.total_bytes, got.total_bytes);
    check_field("last_result", 32'(want.last_result), 32'(got.last_result));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result beat, expected none, got %h", $time, out_data);
        end else begin
          compare_result(results_due.pop_front(), out_data);
        end
        case (out_data.result_kind)
          xcr_pkg::RK_PAYLOAD: payload_seen++;
          xcr_pkg::RK_VERDICT: begin
            verdicts_seen++;
            if (out_data.verdict == xcr_pkg::VD_ACCEPT) accepts_seen++;
          end
          xcr_pkg::RK_FINISH: finishes_seen++;
          default: ;
        endcase
        out_hold = pick_wait(out_stretch, out_steady);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_ready <= (out_hold == 0);
    end
  end

  // ---------------------------------------------------------------- stimulus
  int sessions_run = 0;
  int limits_used = 0;

  task automatic queue_event(logic [1:0] k, logic [7:0] b);
    xcr_pkg::in_item_t it;
    it.event_kind = k;
    it.line_byte  = b;
    line_events.push_back(it);
  endtask

  // header, sequence, complement, payload, CRC; optionally cut short after a few bytes
  task automatic queue_frame(logic [7:0] hdr, logic [7:0] seq, int len, flaw_t flaw);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    logic [7:0]  d;
    int          keep;
    crc = '0;
    frame.push_back(hdr);
    frame.push_back(seq);
    frame.push_back(~seq);
    for (int i = 0; i < len; i++) begin
      d   = 8'($urandom_range(0, 255));
      crc = crc16_step(crc, d);
      frame.push_back(d);
    end
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    keep = (flaw == FLAW_CUT) ? $urandom_range(1, 6) : frame.size();
    for (int i = 0; i < keep; i++) queue_event(xcr_pkg::EV_BYTE, frame[i]);
  endtask

  // any byte other than SOH, STX, EOT or CAN
  function automatic logic [7:0] stray_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case (b)
      xcr_pkg::B_SOH, xcr_pkg::B_STX, xcr_pkg::B_EOT, xcr_pkg::B_CAN: b = 8'hFF;
      default: ;
    endcase
    return b;
  endfunction

  // header timeouts, lone CANs and cut packets, then a random ending
  task automatic short_session();
    int left;
    int actions;
    int pick;
    bit ended;
    left  = rx_limit;
    ended = 1'b0;
    queue_event(xcr_pkg::EV_START, 8'($urandom_range(0, 255)));
    actions = $urandom_range(1, 3);
    for (int a = 0; a < actions && !ended; a++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        queue_frame(pick < 20 ? xcr_pkg::B_SOH : stray_byte(), 8'd1, 128, FLAW_CUT);
        queue_event(xcr_pkg::EV_TIMEOUT, 8'($urandom_range(0, 255)));
        queue_event(xcr_pkg::EV_TIMEOUT, 8'($urandom_range(0, 255)));
        left--;
        ended = (left == 0);
      end else begin
        // lone CAN: the timeout still counts against the header
        if (pick < 70) queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_CAN);
        queue_event(xcr_pkg::EV_TIMEOUT, 8'($urandom_range(0, 255)));
        left--;
        if (left == 0) begin
          queue_event(xcr_pkg::EV_TIMEOUT, 8'($urandom_range(0, 255)));
          ended = 1'b1;
        end
      end
    end
    if (!ended) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_EOT);
        queue_event(xcr_pkg::EV_TIMEOUT, 8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_CAN);
        queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_CAN);
        queue_event(xcr_pkg::EV_TIMEOUT, 8'($urandom_range(0, 255)));
      end
    end
    repeat ($urandom_range(0, 2))
      queue_event(2'($urandom_range(1, 2)), 8'($urandom_range(0, 255)));
    sessions_run++;
  endtask

  // one clean short packet, then end of transfer
  task automatic packet_session();
    queue_event(xcr_pkg::EV_START, 8'h00);
    queue_frame(xcr_pkg::B_SOH, 8'd1, xcr_pkg::SHORT_PAYLOAD, FLAW_NONE);
    queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_EOT);
    queue_event(xcr_pkg::EV_TIMEOUT, 8'h00);
    sessions_run++;
  endtask

  task automatic write_retry_limit(logic [6:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rx_limit = v;
    limits_used++;
  endtask

  // hold off until every beat is out, then let the pipeline go quiet
  task automatic drain_all();
    while (line_events.size() != 0 || in_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_retry_limit(7'd127);
    // idle noise, spare event code, retransmits, lone CAN, packet timeout,
    // flush, EOT and remote cancel, restart mid-packet
    queue_event(xcr_pkg::EV_BYTE, 8'hFF);
    queue_event(xcr_pkg::EV_TIMEOUT, 8'h00);
    queue_event(EV_SPARE, 8'hAA);
    queue_event(xcr_pkg::EV_START, 8'h00);
    queue_event(xcr_pkg::EV_TIMEOUT, 8'h00);
    queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_CAN);
    queue_event(xcr_pkg::EV_TIMEOUT, 8'hFF);
    queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_CAN);
    queue_event(xcr_pkg::EV_BYTE, 8'h00);
    queue_event(xcr_pkg::EV_BYTE, 8'hFF);
    queue_event(xcr_pkg::EV_TIMEOUT, 8'h00);
    queue_event(xcr_pkg::EV_BYTE, 8'h55);
    queue_event(xcr_pkg::EV_TIMEOUT, 8'h00);
    queue_event(xcr_pkg::EV_TIMEOUT, 8'h00);
    queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_EOT);
    queue_event(xcr_pkg::EV_TIMEOUT, 8'h00);
    queue_event(xcr_pkg::EV_START, 8'hFF);
    queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_SOH);
    queue_event(xcr_pkg::EV_BYTE, 8'h01);
    queue_event(xcr_pkg::EV_START, 8'h00);
    queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_CAN);
    queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_CAN);
    queue_event(xcr_pkg::EV_TIMEOUT, 8'h00);
    queue_event(xcr_pkg::EV_BYTE, xcr_pkg::B_STX);
    drain_all();

    write_retry_limit(7'($urandom_range(1, 3)));
    short_session();
    drain_all();

    write_retry_limit(7'd16);
    packet_session();
    drain_all();

    $display("Ran %0d sessions under %0d retry limits: %0d events, %0d result beats checked",
             sessions_run, limits_used, events_sent, results_seen);
    $display("Seen %0d payload bytes, %0d verdicts (%0d accepted), %0d session ends",
             payload_seen, verdicts_seen, accepts_seen, finishes_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
